### rtl/core/itrd_pkg.sv
// shared types and constants of the integer to radix digits converter
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned NUM_SYMBOLS = 16;
  localparam int unsigned MAX_SYMBOLS = 16;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ALPHA_W     = NUM_SYMBOLS * SYM_W;

  // value bits the divider consumes per cycle
  localparam int unsigned DIV_STEP_BITS = 4;

  localparam logic [SYM_W-1:0]   CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0]   CH_MINUS  = 8'h2D;
  localparam logic [COUNT_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

  typedef struct packed {
    logic               digit_valid;
    logic               quot_zero;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

endpackage

### rtl/core/itrd_alpha_check.sv
// alphabet validity check over the configured digit symbols
`timescale 1ns / 1ps

module itrd_alpha_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [itrd_pkg::COUNT_W-1:0]       digit_count_i,
  input  logic [itrd_pkg::ALPHA_W-1:0]       symbols_i,
  output logic                               ok_o
);

  logic ok_d, ok_q;

  always_comb begin
    logic [itrd_pkg::SYM_W-1:0] ci;
    logic [itrd_pkg::SYM_W-1:0] cj;
    ok_d = 1'b1;
    if (digit_count_i < itrd_pkg::MIN_RADIX ||
        digit_count_i > itrd_pkg::COUNT_W'(itrd_pkg::MAX_SYMBOLS)) begin
      ok_d = 1'b0;
    end
    for (int i = 0; i < itrd_pkg::NUM_SYMBOLS; i++) begin
      ci = symbols_i[i*itrd_pkg::SYM_W +: itrd_pkg::SYM_W];
      if (itrd_pkg::COUNT_W'(i) < digit_count_i) begin
        if (ci == '0 || ci == itrd_pkg::CH_PLUS || ci == itrd_pkg::CH_MINUS) begin
          ok_d = 1'b0;
        end
      end
      for (int j = i + 1; j < itrd_pkg::NUM_SYMBOLS; j++) begin
        cj = symbols_i[j*itrd_pkg::SYM_W +: itrd_pkg::SYM_W];
        // the later symbol inside the count implies the earlier one is too
        if (itrd_pkg::COUNT_W'(j) < digit_count_i && ci == cj) begin
          ok_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  assign ok_o = ok_q;

endmodule

### rtl/core/itrd_divider.sv
// digit serial divider: divides the magnitude by the radix a few bits per cycle
`timescale 1ns / 1ps

module itrd_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrd_pkg::div_ctrl_t           ctrl_i,
  input  logic [VALUE_BITS-1:0]         mag_i,
  input  logic [itrd_pkg::COUNT_W-1:0]  radix_i,
  output itrd_pkg::div_stat_t           stat_o
);

  localparam int unsigned STEP_BITS = itrd_pkg::DIV_STEP_BITS;
  localparam int unsigned QW        = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned STEPS     = QW / STEP_BITS;
  localparam int unsigned CNT_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned REM_W     = itrd_pkg::COUNT_W + 1;

  logic [QW-1:0]                   num_q, num_d;
  logic [itrd_pkg::COUNT_W-1:0]    rem_q;
  logic [REM_W-1:0]                rem;
  logic [STEP_BITS-1:0]            qbits;
  logic [CNT_W-1:0]                cnt_q;
  logic                            last_step;

  // restoring division, one quotient bit per inner step
  always_comb begin
    rem   = {1'b0, rem_q};
    qbits = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      rem = {rem[REM_W-2:0], num_q[QW-1-k]};
      if (rem >= {1'b0, radix_i}) begin
        rem                    = rem - {1'b0, radix_i};
        qbits[STEP_BITS-1-k]   = 1'b1;
      end
    end
    num_d = {num_q[QW-STEP_BITS-1:0], qbits};
  end

  assign last_step = (cnt_q == CNT_W'(STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= '0;
    end else if (ctrl_i.run) begin
      cnt_q <= last_step ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= QW'(mag_i);
      rem_q <= '0;
    end else if (ctrl_i.run) begin
      num_q <= num_d;
      rem_q <= last_step ? '0 : rem[itrd_pkg::COUNT_W-1:0];
    end
  end

  assign stat_o.digit_valid = ctrl_i.run & last_step;
  assign stat_o.quot_zero   = (num_d == '0);
  assign stat_o.digit       = rem[itrd_pkg::DIGIT_W-1:0];

endmodule

### rtl/core/integer_to_radix_digits.sv
// top level: signed integer to text in a configurable radix
//
// Usage: drive value_i and pulse start while busy is low; the request is taken
// at that edge and busy stays high until the final character has been issued.
// Characters leave on char_out_o with char_valid_o high for exactly one cycle,
// one per cycle; last_o marks the final character of the value. A negative
// value gives a leading minus sign, the most negative value prints 2^(N-1).
// The alphabet is written through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle: index 0 digit count, 1 symbols 0..7, 2 symbols 8..15. An
// invalid alphabet gives no characters at all for the request.
// Sequence: the divider produces the digits least significant first, each
// one after a full pass over the magnitude, four value bits per step; a
// negative value then passes through a sign state that issues the minus sign.
// Characters then leave one per cycle from the digit stack, and busy drops
// with the final character, which shows in the first idle cycle. An invalid
// alphabet keeps dividing until the quotient is exhausted or the digit stack
// is full before busy drops. The receiver cannot stall.
// Reset clears the configuration to zero (invalid alphabet) and idles the block.
`timescale 1ns / 1ps

module integer_to_radix_digits #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [VALUE_BITS-1:0]      value_i,
  input  logic                              cfg_we_i,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              char_valid_o,
  output logic [itrd_pkg::SYM_W-1:0]        char_out_o,
  output logic                              last_o
);

  localparam int unsigned NW = $clog2(VALUE_BITS + 1);

  itrd_pkg::state_e                 state_q, state_d;
  logic [itrd_pkg::COUNT_W-1:0]     digit_count_q;
  logic [itrd_pkg::CFG_DATA_W-1:0]  symbols_low_q;
  logic [itrd_pkg::CFG_DATA_W-1:0]  symbols_high_q;
  logic [itrd_pkg::ALPHA_W-1:0]     symbols;
  logic                             alpha_ok;

  logic [VALUE_BITS-1:0]            val_u;
  logic [VALUE_BITS-1:0]            mag;
  logic                             neg_q;
  logic [NW-1:0]                    ndig_q, ndig_d;
  logic [itrd_pkg::DIGIT_W-1:0]     stack_q [VALUE_BITS];
  logic                             push, pop;

  itrd_pkg::div_ctrl_t              div_ctrl;
  itrd_pkg::div_stat_t              div_stat;

  logic                             char_valid_d, char_valid_q;
  logic [itrd_pkg::SYM_W-1:0]       char_d, char_q;
  logic                             last_d, last_q;
  logic                             accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q  <= '0;
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        itrd_pkg::CFG_DIGIT_COUNT:  digit_count_q  <= cfg_data_i[itrd_pkg::COUNT_W-1:0];
        itrd_pkg::CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data_i;
        itrd_pkg::CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign symbols = {symbols_high_q, symbols_low_q};

  itrd_alpha_check u_alpha_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .digit_count_i (digit_count_q),
    .symbols_i     (symbols),
    .ok_o          (alpha_ok)
  );

  assign accept = start & ~busy;
  assign val_u  = value_i;
  assign mag    = val_u[VALUE_BITS-1] ? (~val_u + 1'b1) : val_u;

  assign div_ctrl.load = accept;
  assign div_ctrl.run  = (state_q == itrd_pkg::ST_DIV);

  itrd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .mag_i   (mag),
    .radix_i (digit_count_q),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d      = state_q;
    ndig_d       = ndig_q;
    push         = 1'b0;
    pop          = 1'b0;
    char_valid_d = 1'b0;
    char_d       = '0;
    last_d       = 1'b0;
    unique case (state_q)
      itrd_pkg::ST_IDLE: begin
        if (start) begin
          ndig_d  = '0;
          state_d = itrd_pkg::ST_DIV;
        end
      end
      itrd_pkg::ST_DIV: begin
        if (div_stat.digit_valid) begin
          push   = 1'b1;
          ndig_d = ndig_q + 1'b1;
          // quotient exhausted or stack full ends the division
          if (div_stat.quot_zero || ndig_q == NW'(VALUE_BITS - 1)) begin
            if (!alpha_ok) begin
              state_d = itrd_pkg::ST_IDLE;
            end else if (neg_q) begin
              state_d = itrd_pkg::ST_SIGN;
            end else begin
              state_d = itrd_pkg::ST_EMIT;
            end
          end
        end
      end
      itrd_pkg::ST_SIGN: begin
        char_valid_d = 1'b1;
        char_d       = itrd_pkg::CH_MINUS;
        state_d      = itrd_pkg::ST_EMIT;
      end
      itrd_pkg::ST_EMIT: begin
        pop          = 1'b1;
        char_valid_d = 1'b1;
        char_d       = symbols[{stack_q[0], 3'b000} +: itrd_pkg::SYM_W];
        last_d       = (ndig_q == NW'(1));
        ndig_d       = ndig_q - 1'b1;
        if (ndig_q == NW'(1)) begin
          state_d = itrd_pkg::ST_IDLE;
        end
      end
      default: state_d = itrd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= itrd_pkg::ST_IDLE;
      ndig_q       <= '0;
      char_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ndig_q       <= ndig_d;
      char_valid_q <= char_valid_d;
    end
  end

  // digit stack: push and pop at entry zero, most significant digit ends on top
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= val_u[VALUE_BITS-1];
    end
    if (push) begin
      stack_q[0] <= div_stat.digit;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy         = (state_q != itrd_pkg::ST_IDLE);
  assign char_valid_o = char_valid_q;
  assign char_out_o   = char_q;
  assign last_o       = last_q;

endmodule

### tb/testbench.sv
// self-checking testbench for the integer to radix digits converter
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned QUIET_ITEMS   = 80;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [itrd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [VALUE_BITS-1:0] INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] INT_MAX = ~INT_MIN;

  // symbol 0 sits in the low byte
  localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DEC_HIGH = 64'h0000_0000_0000_3938;
  localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;
  // bytes past the count hold sign chars, zero and repeats, all of which must be ignored
  localparam logic [63:0] BIN_LOW  = 64'h2B2D_0031_3031_3130;

  typedef struct packed {
    logic [itrd_pkg::SYM_W-1:0] ch;
    logic                       is_last;
  } char_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic signed [VALUE_BITS-1:0]      value_i;
  logic                              cfg_we_i;
  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_idx_i;
  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data_i;
  logic                              char_valid_o;
  logic [itrd_pkg::SYM_W-1:0]        char_out_o;
  logic                              last_o;

  // predictor copy of the registers, alphabet is {symbols_high, symbols_low}
  logic [itrd_pkg::COUNT_W-1:0] radix_q;
  logic [itrd_pkg::ALPHA_W-1:0] alphabet_q;

  char_t       pending_chars[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned printing_items = 0;
  bit          gaps_on;

  integer_to_radix_digits #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .char_valid_o(char_valid_o),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_t want;
    if (rst_ni && char_valid_o) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected char %h last %b", char_out_o, last_o);
      end else begin
        want = pending_chars.pop_front();
        if (char_out_o !== want.ch || last_o !== want.is_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.is_last, char_out_o, last_o);
        end
      end
    end
  end

  function automatic logic [itrd_pkg::SYM_W-1:0] symbol_at(int unsigned i);
    return alphabet_q[itrd_pkg::SYM_W*i +: itrd_pkg::SYM_W];
  endfunction

  function automatic bit alphabet_valid();
    if (radix_q < itrd_pkg::MIN_RADIX || radix_q > itrd_pkg::MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < radix_q; i++) begin
      if (symbol_at(i) == '0 || symbol_at(i) == itrd_pkg::CH_PLUS ||
          symbol_at(i) == itrd_pkg::CH_MINUS)
        return 1'b0;
      for (int j = i + 1; j < radix_q; j++)
        if (symbol_at(j) == symbol_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [itrd_pkg::CFG_IDX_W-1:0]  idx,
                                    logic [itrd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      itrd_pkg::CFG_DIGIT_COUNT:  radix_q = data[itrd_pkg::COUNT_W-1:0];
      itrd_pkg::CFG_SYMBOLS_LOW:  alphabet_q[63:0] = data;
      itrd_pkg::CFG_SYMBOLS_HIGH: alphabet_q[127:64] = data;
      default: ;
    endcase
  endfunction

  // queues the characters of one request, returns how many
  function automatic int unsigned predict_text(logic signed [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0]          mag;
    logic [itrd_pkg::DIGIT_W-1:0]   digits[$];
    if (!alphabet_valid()) return 0;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    if (v[VALUE_BITS-1])
      pending_chars.push_back('{ch: itrd_pkg::CH_MINUS, is_last: 1'b0});
    do begin
      digits.push_front(itrd_pkg::DIGIT_W'(mag % radix_q));
      mag = mag / radix_q;
    end while (mag != 0);
    foreach (digits[i])
      pending_chars.push_back('{ch: symbol_at(digits[i]), is_last: (i == digits.size() - 1)});
    return v[VALUE_BITS-1] + digits.size();
  endfunction

  function automatic logic [itrd_pkg::CFG_DATA_W-1:0] count_word(int unsigned n);
    logic [itrd_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[itrd_pkg::COUNT_W-1:0] = itrd_pkg::COUNT_W'(n);
    return w;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] r;
    case ($urandom_range(0, 9))
      0:       r = INT_MIN;
      1:       r = INT_MAX;
      2:       r = $urandom_range(0, 1) ? '0 : '1;
      3, 4:    r = $urandom_range(0, 40);
      5, 6:    r = $urandom >> $urandom_range(0, 31);
      default: r = $urandom;
    endcase
    if (r != INT_MIN && $urandom_range(0, 1)) r = ~r + 1'b1;
    return r;
  endfunction

  task automatic send_value(logic signed [VALUE_BITS-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start   = 1'b1;
    value_i = v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (predict_text(v) != 0) printing_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    while (busy) @(posedge clk_i);
    // a request with no output may still be dividing
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [itrd_pkg::CFG_IDX_W-1:0]  idx,
                           logic [itrd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_alphabet(logic [63:0] cnt, logic [63:0] lo, logic [63:0] hi);
    logic [itrd_pkg::CFG_DATA_W-1:0] word[4];
    logic [itrd_pkg::CFG_IDX_W-1:0]  idx;
    int unsigned                     first;
    word[itrd_pkg::CFG_DIGIT_COUNT]  = cnt;
    word[itrd_pkg::CFG_SYMBOLS_LOW]  = lo;
    word[itrd_pkg::CFG_SYMBOLS_HIGH] = hi;
    wait_idle();
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      idx = itrd_pkg::CFG_IDX_W'((first + k) % 3);
      write_reg(idx, word[idx]);
    end
  endtask

  task automatic test_reset_alphabet();
    send_value(INT_MIN);
    send_value(12345);
  endtask

  task automatic test_invalid_alphabets();
    load_alphabet(count_word(0), DEC_LOW, DEC_HIGH);
    send_value(7);
    load_alphabet(count_word(1), DEC_LOW, DEC_HIGH);
    send_value(-7);
    load_alphabet(count_word(17), DEC_LOW, HEX_HIGH);
    send_value(100);
    load_alphabet(count_word(31), DEC_LOW, HEX_HIGH);
    send_value(INT_MAX);
    load_alphabet(count_word(10), DEC_LOW, {48'h0, itrd_pkg::CH_PLUS, 8'h38});
    send_value(55);
    load_alphabet(count_word(10), {DEC_LOW[63:8], itrd_pkg::CH_MINUS}, DEC_HIGH);
    send_value(-55);
    load_alphabet(count_word(16), DEC_LOW, {8'h00, HEX_HIGH[55:0]});
    send_value(255);
    // symbol 9 repeats symbol 0
    load_alphabet(count_word(10), DEC_LOW, {48'h0, 8'h30, 8'h38});
    send_value(90);
  endtask

  task automatic test_decimal_extremes();
    load_alphabet(count_word(10), DEC_LOW, DEC_HIGH);
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(-10);
    send_value(INT_MAX);
    send_value(INT_MIN);
    wait_drained();
  endtask

  task automatic test_binary_and_hex();
    load_alphabet(count_word(2), BIN_LOW, HEX_HIGH);
    send_value(INT_MIN);
    send_value(INT_MAX);
    send_value(-1);
    load_alphabet(count_word(16), DEC_LOW, HEX_HIGH);
    send_value(INT_MIN);
    send_value(32'hDEAD_BEEF);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    send_value(-123456);
  endtask

  task automatic random_phase(int unsigned n_items);
    logic [itrd_pkg::ALPHA_W-1:0] syms;
    logic [itrd_pkg::SYM_W-1:0]   c;
    bit                           taken[256];
    int unsigned                  n;
    int unsigned                  i;
    int unsigned                  j;
    bit                           broken;
    case ($urandom_range(0, 5))
      0:       n = 2;
      1:       n = 16;
      default: n = $urandom_range(2, 16);
    endcase
    syms = {$urandom, $urandom, $urandom, $urandom};
    foreach (taken[k]) taken[k] = 1'b0;
    for (int k = 0; k < n; k++) begin
      do c = itrd_pkg::SYM_W'($urandom_range(1, 255));
      while (taken[c] || c == itrd_pkg::CH_PLUS || c == itrd_pkg::CH_MINUS);
      taken[c] = 1'b1;
      syms[itrd_pkg::SYM_W*k +: itrd_pkg::SYM_W] = c;
    end
    broken = ($urandom_range(0, 5) == 0);
    if (broken) begin
      i = $urandom_range(0, n - 2);
      j = $urandom_range(i + 1, n - 1);
      case ($urandom_range(0, 5))
        0: n = $urandom_range(0, 1);
        1: n = $urandom_range(17, 31);
        2: syms[itrd_pkg::SYM_W*j +: itrd_pkg::SYM_W] = itrd_pkg::CH_PLUS;
        3: syms[itrd_pkg::SYM_W*i +: itrd_pkg::SYM_W] = itrd_pkg::CH_MINUS;
        4: syms[itrd_pkg::SYM_W*j +: itrd_pkg::SYM_W] = '0;
        default: syms[itrd_pkg::SYM_W*j +: itrd_pkg::SYM_W] =
                   syms[itrd_pkg::SYM_W*i +: itrd_pkg::SYM_W];
      endcase
    end
    load_alphabet(count_word(n), syms[63:0], syms[127:64]);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    if (broken) n_items = 4;
    for (int k = 0; k < n_items; k++) begin
      if (gaps_on && $urandom_range(0, 29) == 0) wait_drained();
      send_value(random_value());
    end
  endtask

  task automatic test_random_alphabets();
    int unsigned base;
    base = printing_items;
    while (printing_items - base < RANDOM_ITEMS) begin
      if (printing_items - base >= RANDOM_ITEMS - QUIET_ITEMS) gaps_on = 1'b0;
      random_phase($urandom_range(10, 30));
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    value_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = itrd_pkg::CFG_DIGIT_COUNT;
    cfg_data_i = '0;
    radix_q    = '0;
    alphabet_q = '0;
    gaps_on    = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_alphabet();
    test_invalid_alphabets();
    test_decimal_extremes();
    test_binary_and_hex();
    test_unused_index();
    test_random_alphabets();

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
